[rtl/core/wbgm_pkg.sv]
package wbgm_pkg;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned P_W    = 33;
  localparam int unsigned W_W    = 32;
  localparam int unsigned SUM_W  = 52;
  localparam int unsigned POS_W  = 21;
  localparam int unsigned PROD_W = P_W + W_W;      // cross-multiplication product
  localparam int unsigned NUM_W  = W_W + SUM_W;    // p * weight_sum, p below 1.0 or exactly 1.0
  localparam int unsigned HALF_W = SUM_W / 2;      // sum split for the partial products

  localparam logic [P_W-1:0]   P_ONE     = {1'b1, {(P_W-1){1'b0}}};
  localparam logic [POS_W-1:0] MAX_ITEMS = POS_W'(1048576);

  // job queue between front and back
  localparam int unsigned JQ_DEPTH = 4;
  localparam int unsigned JQ_AW    = $clog2(JQ_DEPTH);

  typedef struct packed {
    logic             err;     // unsorted id error transaction
    logic             last;    // final result of its input item
    logic [P_W-1:0]   p;
    logic [W_W-1:0]   w;
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] pos;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_A,
    F_MUL_B,
    F_DECIDE,
    F_LAST
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL_LO,
    B_MUL_HI,
    B_CHECK,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

[rtl/core/weighted_bonferroni_group_min_core.sv]
// Path: an item passes front states MUL_A, MUL_B, DECIDE, and LAST when it closes the set;
//   a cluster result then takes 2 multiply steps, 1 range check and 32 divide steps in the
//   back (no divide when p is zero or the result saturates); error jobs skip to output.
// Flow: one item, and one job, at a time; the front stalls while the 4-entry queue is full.
// Reset: synchronous, active low; clears cluster state, queue and output valid flag.
module weighted_bonferroni_group_min_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [wbgm_pkg::ID_W-1:0] in_cluster_id,
  input  logic [wbgm_pkg::P_W-1:0]       in_p_value,
  input  logic [wbgm_pkg::W_W-1:0]       in_weight,
  input  logic                           in_last_item,
  input  logic                           in_push,
  output logic                           in_full,
  output logic [wbgm_pkg::P_W-1:0]       out_adjusted_p,
  output logic [wbgm_pkg::POS_W-1:0]     out_best_index,
  output logic                           out_status,
  output logic                           out_last_result,
  output logic                           out_empty,
  input  logic                           out_pop
);
  import wbgm_pkg::*;

  // front: running per-cluster minimum of p/w by cross-multiplication,
  // id ordering check and closing of clusters into jobs
  job_t push_job, pop_job;
  logic job_push, job_full, job_pop, job_empty;

  wbgm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cluster_id (in_cluster_id),
    .in_p_value    (in_p_value),
    .in_weight     (in_weight),
    .in_last_item  (in_last_item),
    .in_push       (in_push),
    .in_full       (in_full),
    .job_push      (job_push),
    .job           (push_job),
    .job_full      (job_full)
  );

  // short queue so the front keeps taking items while the divider works
  wbgm_job_q u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .empty    (job_empty)
  );

  // back: adjusted p = floor(p * weight_sum / weight), saturated at 1.0,
  // into a single output register that decouples the result side
  wbgm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (pop_job),
    .job_empty       (job_empty),
    .job_pop         (job_pop),
    .out_adjusted_p  (out_adjusted_p),
    .out_best_index  (out_best_index),
    .out_status      (out_status),
    .out_last_result (out_last_result),
    .out_empty       (out_empty),
    .out_pop         (out_pop)
  );

endmodule

[rtl/core/wbgm_front.sv]
module wbgm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [wbgm_pkg::ID_W-1:0] in_cluster_id,
  input  logic [wbgm_pkg::P_W-1:0]       in_p_value,
  input  logic [wbgm_pkg::W_W-1:0]       in_weight,
  input  logic                           in_last_item,
  input  logic                           in_push,
  output logic                           in_full,
  output logic                           job_push,
  output wbgm_pkg::job_t                 job,
  input  logic                           job_full
);
  import wbgm_pkg::*;

  front_state_t state_r, state_nxt;

  logic signed [ID_W-1:0] id_r, prev_id_r;
  logic [P_W-1:0]         p_r, best_p_r;
  logic [W_W-1:0]         w_r, best_w_r;
  logic                   last_r;
  logic [SUM_W-1:0]       wsum_r;
  logic [POS_W-1:0]       best_pos_r, count_r;
  logic                   open_r, err_r;
  logic [PROD_W-1:0]      prod_a_r, prod_b_r;

  logic [P_W-1:0]    mul_x;
  logic [W_W-1:0]    mul_y;
  logic [PROD_W-1:0] mul_out;
  logic [POS_W-1:0]  count_inc;
  logic              is_desc, is_new, better, advance;
  logic [SUM_W:0]    sum_add;

  // one shared multiplier: candidate p * best weight, then best p * candidate weight
  assign mul_x   = (state_r == F_MUL_A) ? p_r : best_p_r;
  assign mul_y   = (state_r == F_MUL_A) ? best_w_r : w_r;
  assign mul_out = PROD_W'(mul_x) * PROD_W'(mul_y);

  assign count_inc = (count_r < MAX_ITEMS) ? count_r + POS_W'(1) : count_r;
  assign is_desc   = open_r && (id_r < prev_id_r);
  assign is_new    = open_r && (id_r != prev_id_r);
  assign better    = prod_a_r < prod_b_r;
  assign sum_add   = {1'b0, wsum_r} + (SUM_W+1)'(w_r);
  assign advance   = err_r || !job_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:   if (in_push) state_nxt = F_MUL_A;
      F_MUL_A:  state_nxt = F_MUL_B;
      F_MUL_B:  state_nxt = F_DECIDE;
      F_DECIDE: begin
        if (advance) begin
          if (err_r || is_desc || !last_r) state_nxt = F_IDLE;
          else                             state_nxt = F_LAST;
        end
      end
      F_LAST:   if (!job_full) state_nxt = F_IDLE;
      default:  state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_full  = 1'b1;
    job_push = 1'b0;
    job.err  = 1'b0;
    job.last = 1'b1;
    job.p    = best_p_r;
    job.w    = best_w_r;
    job.sum  = wsum_r;
    job.pos  = best_pos_r;
    unique case (state_r)
      F_IDLE:   in_full = 1'b0;
      F_DECIDE: begin
        job_push = !err_r && !job_full && (is_desc || is_new);
        job.err  = is_desc;
        job.last = is_desc || !last_r;
      end
      F_LAST:   job_push = !job_full;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      count_r    <= '0;
      open_r     <= 1'b0;
      err_r      <= 1'b0;
      prev_id_r  <= '0;
      best_p_r   <= '0;
      best_w_r   <= '0;
      wsum_r     <= '0;
      best_pos_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_IDLE && in_push) begin
        id_r   <= in_cluster_id;
        p_r    <= (in_p_value > P_ONE) ? P_ONE : in_p_value;
        w_r    <= in_weight;
        last_r <= in_last_item;
      end
      if (state_r == F_MUL_A) prod_a_r <= mul_out;
      if (state_r == F_MUL_B) prod_b_r <= mul_out;
      if (state_r == F_DECIDE && advance) begin
        if (err_r) begin
          if (last_r) begin
            count_r <= '0;
            err_r   <= 1'b0;
          end
        end else if (is_desc) begin
          open_r <= 1'b0;
          if (last_r) begin
            count_r <= '0;
          end else begin
            count_r <= count_inc;
            err_r   <= 1'b1;
          end
        end else begin
          count_r <= count_inc;
          if (is_new || !open_r) begin
            prev_id_r  <= id_r;
            best_p_r   <= p_r;
            best_w_r   <= w_r;
            wsum_r     <= SUM_W'(w_r);
            best_pos_r <= count_inc;
            open_r     <= 1'b1;
          end else begin
            wsum_r <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            if (better) begin
              best_p_r   <= p_r;
              best_w_r   <= w_r;
              best_pos_r <= count_inc;
            end
          end
        end
      end
      if (state_r == F_LAST && !job_full) begin
        count_r <= '0;
        open_r  <= 1'b0;
        err_r   <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/wbgm_job_q.sv]
module wbgm_job_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wbgm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output wbgm_pkg::job_t pop_job,
  output logic           empty
);
  import wbgm_pkg::*;

  job_t             slot_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [JQ_AW:0]   count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == (JQ_AW+1)'(JQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        slot_r[wr_ptr_r] <= push_job;
        wr_ptr_r         <= wr_ptr_r + JQ_AW'(1);
      end
      if (do_pop) rd_ptr_r <= rd_ptr_r + JQ_AW'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (JQ_AW+1)'(1);
        2'b01:   count_r <= count_r - (JQ_AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/core/wbgm_back.sv]
module wbgm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wbgm_pkg::job_t                 job,
  input  logic                           job_empty,
  output logic                           job_pop,
  output logic [wbgm_pkg::P_W-1:0]       out_adjusted_p,
  output logic [wbgm_pkg::POS_W-1:0]     out_best_index,
  output logic                           out_status,
  output logic                           out_last_result,
  output logic                           out_empty,
  input  logic                           out_pop
);
  import wbgm_pkg::*;

  localparam int unsigned PART_W = W_W + HALF_W;
  localparam int unsigned CNT_W  = $clog2(W_W);

  back_state_t state_r, state_nxt;

  job_t             job_r;
  logic [NUM_W-1:0] acc_r;
  logic [W_W-1:0]   rem_r, qsh_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   res_r;
  logic             out_valid_r;

  logic [HALF_W-1:0] mul_y;
  logic [PART_W-1:0] mul_out;
  logic [W_W:0]      trial, trial_sub;
  logic              ge, sat, load_out;
  logic [W_W-1:0]    qsh_nxt;

  // p below 1.0 times one half of the weight sum
  assign mul_y   = (state_r == B_MUL_LO) ? job_r.sum[HALF_W-1:0] : job_r.sum[SUM_W-1:HALF_W];
  assign mul_out = PART_W'(job_r.p[W_W-1:0]) * PART_W'(mul_y);

  // quotient reaches 1.0 exactly when the upper numerator bits reach the weight; a zero weight also saturates
  assign sat = (job_r.w == '0) || (acc_r[NUM_W-1:W_W] >= (NUM_W-W_W)'(job_r.w));

  // restoring division, one quotient bit a cycle
  assign trial     = {rem_r, qsh_r[W_W-1]};
  assign ge        = trial >= {1'b0, job_r.w};
  assign trial_sub = trial - {1'b0, job_r.w};
  assign qsh_nxt   = {qsh_r[W_W-2:0], ge};

  assign load_out  = (state_r == B_OUT) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!job_empty) state_nxt = job.err ? B_OUT : B_MUL_LO;
      end
      B_MUL_LO: state_nxt = B_MUL_HI;
      B_MUL_HI: state_nxt = B_CHECK;
      B_CHECK:  state_nxt = ((job_r.p == '0) || sat) ? B_OUT : B_DIV;
      B_DIV:    if (cnt_r == '0) state_nxt = B_OUT;
      B_OUT:    if (load_out) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    unique case (state_r)
      B_IDLE:  job_pop = !job_empty;
      default: job_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        B_IDLE: begin
          if (!job_empty) begin
            job_r <= job;
            res_r <= '0;
          end
        end
        B_MUL_LO: acc_r <= NUM_W'(mul_out);
        B_MUL_HI: begin
          if (job_r.p[P_W-1]) acc_r <= {job_r.sum, {W_W{1'b0}}};
          else                acc_r <= acc_r + {mul_out, {HALF_W{1'b0}}};
        end
        B_CHECK: begin
          if (job_r.p == '0) begin
            res_r <= '0;
          end else if (sat) begin
            res_r <= P_ONE;
          end else begin
            rem_r <= acc_r[2*W_W-1:W_W];
            qsh_r <= acc_r[W_W-1:0];
            cnt_r <= CNT_W'(W_W-1);
          end
        end
        B_DIV: begin
          rem_r <= ge ? trial_sub[W_W-1:0] : trial[W_W-1:0];
          qsh_r <= qsh_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) res_r <= {1'b0, qsh_nxt};
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid_r     <= 1'b1;
        out_adjusted_p  <= res_r;
        out_best_index  <= job_r.err ? '0 : job_r.pos;
        out_status      <= job_r.err;
        out_last_result <= job_r.last;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
